[src/assert_macros.svh]
// Assertion macros shared by the RTL files of the frame parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that c holds in the same cycle as a.
`define ASSERT_SAME(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed: same-cycle implication");

// Check that c holds in the cycle after a.
`define ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed: next-cycle implication");

`endif

[src/ffcp_pkg.sv]
// Package with the types and constants of the fixed frame command parser.
package ffcp_pkg;

  localparam logic [7:0] HDR_FIRST  = 8'h2C;
  localparam logic [7:0] HDR_SECOND = 8'h12;
  localparam logic [7:0] FRAME_TAIL = 8'h5B;
  localparam logic [7:0] FILL_BYTE  = 8'hFF;

  localparam int FRAME_LEN = 6;
  localparam int IDX_W     = 3;
  localparam logic [IDX_W-1:0] FRAME_LEN_IDX = IDX_W'(FRAME_LEN);

  localparam int OUT_DATA_W = 32;

  typedef enum logic [1:0] {
    PH_HDR1  = 2'd0,
    PH_HDR2  = 2'd1,
    PH_RECV  = 2'd2,
    PH_CHECK = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_BAD      = 2'd1,
    ST_NO_TAIL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] stop_flag;
    logic [7:0] start_flag;
    logic [7:0] target_item;
    status_t    frame_status;
  } result_t;

endpackage

[src/fixed_frame_command_parser_unit.sv]
// Top level of the fixed frame command parser.
// Takes one received byte per transfer and parses six-byte frames of the form
// 0x2C, 0x12, three payload bytes, 0x5B. Bytes pass through an input register
// and then a single pass of compare logic that updates the parser state; the
// block takes a byte each cycle unless stalled. Only the byte after a completed
// frame (six bytes stored, or an early 0x5B) yields a result, and that byte
// itself is dropped: the result is status (0 accepted, 1 terminator seen but
// check failed, 2 terminator missing) plus the three held command bytes.
// Result valid rises once the check byte has passed the input register and
// its result is loaded into the output register. A result waits in the
// output register while the downstream side stalls; only a check byte that
// meets a full output register holds the input register, all other bytes
// advance regardless. A wrong header byte or a missing terminator fills the
// frame buffer with 0xFF.
`include "assert_macros.svh"

module fixed_frame_command_parser_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [7:0] rx_byte
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [1:0] frame_status, [9:2] target_item, [17:10] start_flag,
  // [25:18] stop_flag, [31:26] zero
  output logic [ffcp_pkg::OUT_DATA_W-1:0] m_tdata
);
  import ffcp_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       check;
  logic       out_free;
  logic       advance;
  result_t    result;

  // Advance the held byte unless it needs the output register and that is busy.
  assign advance  = in_valid && (!check || out_free);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  ffcp_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .rx_byte (in_byte),
    .check   (check),
    .result  (result)
  );

  ffcp_result_reg u_result (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && check),
    .result   (result),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // A held byte that cannot advance must stay put.
  `ASSERT_NEXT(a_hold_byte, clk, rst, in_valid && !advance, in_valid && $stable(in_byte))
  // A stall of the input side only comes from a waiting result.
  `ASSERT_SAME(a_stall_cause, clk, rst, !s_tready, check && m_tvalid && !m_tready)
  // A loaded result shows up as valid in the next cycle.
  `ASSERT_NEXT(a_result_shown, clk, rst, advance && check, m_tvalid)

endmodule

[src/ffcp_parser.sv]
// Frame parser state: phase, write index, frame buffer and held command bytes.
`include "assert_macros.svh"

module ffcp_parser (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic [7:0]      rx_byte,
  output logic            check,
  output ffcp_pkg::result_t result
);
  import ffcp_pkg::*;

  phase_t           phase, phase_next;
  logic [IDX_W-1:0] write_index, write_index_next;
  logic [7:0]       frame_buffer [FRAME_LEN];
  logic [7:0]       frame_buffer_next [FRAME_LEN];
  logic [7:0]       held_item, held_item_next;
  logic [7:0]       held_start, held_start_next;
  logic [7:0]       held_stop, held_stop_next;

  logic [IDX_W-1:0] idx_inc;
  logic [IDX_W-1:0] last_idx;
  logic [7:0]       last_byte;
  logic             tail_ok;
  logic             frame_ok;

  assign idx_inc  = write_index + IDX_W'(1);
  assign last_idx = write_index - IDX_W'(1);

  // Pick the last stored byte; a slot outside the buffer never matches.
  always_comb begin
    last_byte = 8'h00;
    for (int i = 0; i < FRAME_LEN; i++) begin
      if (last_idx == IDX_W'(i)) begin
        last_byte = frame_buffer[i];
      end
    end
  end

  assign tail_ok  = (last_idx < FRAME_LEN_IDX) && (last_byte == FRAME_TAIL);
  assign frame_ok = (frame_buffer[0] == HDR_FIRST) && (frame_buffer[1] == HDR_SECOND) &&
                    (frame_buffer[5] == FRAME_TAIL);

  // Next state.
  always_comb begin
    phase_next       = phase;
    write_index_next = write_index;
    frame_buffer_next = frame_buffer;
    held_item_next   = held_item;
    held_start_next  = held_start;
    held_stop_next   = held_stop;
    case (phase)
      PH_HDR1, PH_HDR2: begin
        if ((phase == PH_HDR1 && rx_byte == HDR_FIRST) ||
            (phase == PH_HDR2 && rx_byte == HDR_SECOND)) begin
          phase_next = (phase == PH_HDR1) ? PH_HDR2 : PH_RECV;
          for (int i = 0; i < FRAME_LEN; i++) begin
            if (write_index == IDX_W'(i)) frame_buffer_next[i] = rx_byte;
          end
          write_index_next = idx_inc;
        end else begin
          phase_next       = PH_HDR1;
          write_index_next = '0;
          for (int i = 0; i < FRAME_LEN; i++) frame_buffer_next[i] = FILL_BYTE;
        end
      end
      PH_RECV: begin
        for (int i = 0; i < FRAME_LEN; i++) begin
          if (write_index == IDX_W'(i)) frame_buffer_next[i] = rx_byte;
        end
        write_index_next = idx_inc;
        if (idx_inc >= FRAME_LEN_IDX || rx_byte == FRAME_TAIL) begin
          phase_next = PH_CHECK;
        end
      end
      PH_CHECK: begin
        phase_next       = PH_HDR1;
        write_index_next = '0;
        if (tail_ok) begin
          if (frame_ok) begin
            held_item_next  = frame_buffer[2];
            held_start_next = frame_buffer[3];
            held_stop_next  = frame_buffer[4];
          end
        end else begin
          for (int i = 0; i < FRAME_LEN; i++) frame_buffer_next[i] = FILL_BYTE;
        end
      end
      default: begin
        phase_next = PH_HDR1;
      end
    endcase
  end

  // Outputs: only a check byte yields a result.
  always_comb begin
    check               = (phase == PH_CHECK);
    result.target_item  = held_item_next;
    result.start_flag   = held_start_next;
    result.stop_flag    = held_stop_next;
    if (!tail_ok) begin
      result.frame_status = ST_NO_TAIL;
    end else if (frame_ok) begin
      result.frame_status = ST_ACCEPTED;
    end else begin
      result.frame_status = ST_BAD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HDR1;
      write_index <= '0;
      held_item   <= '0;
      held_start  <= '0;
      held_stop   <= '0;
      for (int i = 0; i < FRAME_LEN; i++) frame_buffer[i] <= '0;
    end else if (step) begin
      phase       <= phase_next;
      write_index <= write_index_next;
      held_item   <= held_item_next;
      held_start  <= held_start_next;
      held_stop   <= held_stop_next;
      frame_buffer <= frame_buffer_next;
    end
  end

  `ASSERT_SAME(a_recv_idx, clk, rst, phase == PH_RECV, write_index >= IDX_W'(2) && write_index < FRAME_LEN_IDX)
  `ASSERT_SAME(a_check_idx, clk, rst, phase == PH_CHECK, write_index >= IDX_W'(3) && write_index <= FRAME_LEN_IDX)
  `ASSERT_SAME(a_hdr_idx, clk, rst, phase == PH_HDR1, write_index == '0)

endmodule

[src/ffcp_result_reg.sv]
// Result register that holds one parse result until the downstream side takes it.
module ffcp_result_reg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            load,
  input  ffcp_pkg::result_t               result,
  output logic                            free,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [ffcp_pkg::OUT_DATA_W-1:0] m_tdata
);
  import ffcp_pkg::*;

  result_t held;

  assign free     = !m_tvalid || m_tready;
  assign m_tdata  = {(OUT_DATA_W - $bits(result_t))'(0), held};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

endmodule
